>>> design/suffix_automaton_common_substring_assert.svh
// assertion macros for the suffix automaton block
`ifndef SUFFIX_AUTOMATON_COMMON_SUBSTRING_ASSERT_SVH
`define SUFFIX_AUTOMATON_COMMON_SUBSTRING_ASSERT_SVH

// implication checked on every clock edge outside reset
`define SA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define SA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sacs_pkg.sv
// shared constants and types of the suffix automaton block
`default_nettype none
package sacs_pkg;
    localparam int TEXT_LEN_DEF = 4096;
    localparam int SYMBOLS_DEF  = 32;
    localparam int CMD_W = 2;
    localparam int SYM_W = 5;
    localparam int LEN_W = 13;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QSTART = 2'd2,
        CMD_MATCH  = 2'd3
    } cmd_t;
endpackage
`default_nettype wire

>>> design/sacs_stream_if.sv
// valid/ready channel interface carrying one payload word
`default_nettype none
interface sacs_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/suffix_automaton_common_substring.sv
// top level of the suffix automaton common substring block
`default_nettype none
// Suffix automaton over a text with longest-common-substring query matching.
// Each input word is a command (clear, append symbol, start query, match
// symbol) and returns exactly one output word holding the current match
// length, the best length since query start and an append-full flag. The
// state lives in three single-port synchronous memories: transitions (one
// entry per state and symbol), state lengths and suffix links. A sequencer
// issues one read at a time and uses the data in the following cycle.
// Start query and a match on a symbol outside the alphabet go straight to
// the result; a full append does so after reading the last state's length. A
// clear sweeps the root row. An append clears the new state's row, then walks
// the suffix links adding an edge at each step, and checks lengths when an
// existing edge stops the walk; a clone copies the transition row, writes its
// length and links, redirects edges along the link walk and ends the redirect
// walk on a check. A match falls back along suffix links, reading each
// length, and resets to the root when it falls off the root. After reset the
// block sweeps the root row and writes the root length and link before it
// takes the first command. Clear needs no full sweep: a new state's row is
// cleared when it is allocated. One item is in flight at a time; the result
// sits in an output register and the next command is taken the cycle after
// the result word is handed off.
module suffix_automaton_common_substring
    import sacs_pkg::*;
#(
    parameter int TEXT_LEN = TEXT_LEN_DEF,
    parameter int SYMBOLS  = SYMBOLS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    sacs_stream_if.sink   in_ch,
    sacs_stream_if.source out_ch
);
    `include "suffix_automaton_common_substring_assert.svh"

    localparam int NST   = 2 * TEXT_LEN;
    localparam int ST_W  = $clog2(NST);
    localparam int SY_W  = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int TR_D  = NST * SYMBOLS;
    localparam int TA_W  = $clog2(TR_D);
    localparam int SL_W  = $clog2(TEXT_LEN + 1);
    localparam int LK_W  = ST_W + 1;      // msb set means no link
    localparam int SC_W  = SY_W + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_NEWROW, S_ROOT, S_RD_LEN, S_WT_LEN, S_WR_CUR,
        S_W1_RD, S_W1_WT, S_W1_LK, S_W1_LKW,
        S_Q_LEN, S_Q_LENW, S_QP_LEN, S_QP_LENW,
        S_CL_RD, S_CL_WT, S_CL_WR, S_CL_LK, S_CL_LKW, S_CL_LNK,
        S_W2_RD, S_W2_WT, S_W2_LK, S_W2_LKW,
        S_M_RD, S_M_WT, S_M_LK, S_M_LKW, S_M_LEN, S_M_LENW,
        S_OUT
    } state_t;

    state_t state_reg;
    logic [ST_W-1:0] count_reg, last_reg, cur_reg, p_reg, q_reg, cl_reg;
    logic            p_nil_reg;
    logic            init_reg;
    logic [SY_W-1:0] sym_reg;
    logic [SC_W-1:0] idx_reg;
    logic [SL_W-1:0] lenlast_reg, lenp_reg, curlen_reg;
    logic [LK_W-1:0] qlink_reg;
    logic [ST_W-1:0] cstate_reg;
    logic [LEN_W-1:0] clen_reg, best_reg;
    logic            full_reg, ovalid_reg, bad_sym_reg;
    logic [LEN_W-1:0] omatch_reg, obest_reg;

    // memory ports
    logic            tr_we, ln_we, lk_we;
    logic [TA_W-1:0] tr_a;
    logic [ST_W-1:0] ln_a, lk_a;
    logic [ST_W:0]   tr_wd, tr_rd;
    logic [SL_W-1:0] ln_wd, ln_rd;
    logic [LK_W-1:0] lk_wd, lk_rd;

    sacs_ram #(.DEPTH(TR_D), .WIDTH(ST_W + 1)) u_tr
        (.clk(clk), .we(tr_we), .addr(tr_a), .wdata(tr_wd), .rdata(tr_rd));
    sacs_ram #(.DEPTH(NST), .WIDTH(SL_W)) u_ln
        (.clk(clk), .we(ln_we), .addr(ln_a), .wdata(ln_wd), .rdata(ln_rd));
    sacs_ram #(.DEPTH(NST), .WIDTH(LK_W)) u_lk
        (.clk(clk), .we(lk_we), .addr(lk_a), .wdata(lk_wd), .rdata(lk_rd));

    function automatic logic [TA_W-1:0] tadr(input logic [ST_W-1:0] s,
                                            input logic [SY_W-1:0] y);
        logic [TA_W-1:0] r;
        r = TA_W'(s) * TA_W'(SYMBOLS) + TA_W'(y);
        return r;
    endfunction

    localparam logic [LK_W-1:0] NO_LINK = {1'b1, {ST_W{1'b0}}};
    wire logic [ST_W:0] tr_zero = '0;

    assign in_ch.ready   = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_ch.valid  = ovalid_reg;
    assign out_ch.data.match_length = omatch_reg;
    assign out_ch.data.best_length  = obest_reg;
    assign out_ch.data.full_res     = full_reg;

    // memory address/write decode from the sequencer state
    always_comb
    begin
        tr_we = 1'b0; ln_we = 1'b0; lk_we = 1'b0;
        tr_a = tadr(p_reg, sym_reg); ln_a = p_reg; lk_a = p_reg;
        tr_wd = tr_zero; ln_wd = '0; lk_wd = '0;
        unique case (state_reg)
            S_NEWROW:
            begin
                tr_we = 1'b1;
                tr_a  = tadr(cur_reg, idx_reg[SY_W-1:0]);
            end
            S_ROOT: // root has length zero and no suffix link
            begin
                ln_we = 1'b1; ln_a = '0; ln_wd = '0;
                lk_we = 1'b1; lk_a = '0; lk_wd = NO_LINK;
            end
            S_RD_LEN: ln_a = last_reg;
            S_WR_CUR:
            begin
                ln_we = 1'b1; ln_a = cur_reg; ln_wd = lenlast_reg + SL_W'(1);
                lk_we = 1'b1; lk_a = cur_reg; lk_wd = '0;
            end
            S_W1_LK: // write edge to cur, fetch link
            begin
                tr_we = 1'b1; tr_wd = {1'b1, cur_reg};
            end
            S_Q_LEN: ln_a = q_reg;
            S_QP_LEN: ln_a = p_reg;
            // hold the address so the read word is still there for the copy
            S_CL_RD, S_CL_WT: tr_a = tadr(q_reg, idx_reg[SY_W-1:0]);
            S_CL_WR:
            begin
                tr_we = 1'b1; tr_a = tadr(cl_reg, idx_reg[SY_W-1:0]); tr_wd = tr_rd;
            end
            S_CL_LK: lk_a = q_reg;
            S_CL_LNK:
            begin
                ln_we = 1'b1; ln_a = cl_reg; ln_wd = lenp_reg + SL_W'(1);
                lk_we = 1'b1; lk_a = cl_reg; lk_wd = qlink_reg;
            end
            S_W2_LK: // redirect the edge to the clone
            begin
                tr_we = 1'b1; tr_wd = {1'b1, q_reg};
            end
            S_M_RD, S_M_WT: tr_a = tadr(p_reg, sym_reg);
            S_M_LEN: ln_a = p_reg;
            default: ;
        endcase
        // extra link writes done in dedicated states
        if (state_reg == S_CL_LKW)
        begin
            lk_we = 1'b1; lk_a = q_reg; lk_wd = {1'b0, cl_reg};
        end
        if (state_reg == S_OUT && !p_nil_reg && !bad_sym_reg && idx_reg[0])
        begin
            lk_we = 1'b1; lk_a = cur_reg; lk_wd = {1'b0, q_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_NEWROW;  // sweep the root row after reset
            init_reg   <= 1'b1;
            count_reg  <= '0; last_reg <= '0; cur_reg <= '0;
            p_reg      <= '0; q_reg <= '0; cl_reg <= '0;
            sym_reg    <= '0; qlink_reg <= '0;
            lenlast_reg <= '0; lenp_reg <= '0; curlen_reg <= '0;
            cstate_reg <= '0; clen_reg <= '0; best_reg <= '0;
            ovalid_reg <= 1'b0; full_reg <= 1'b0;
            omatch_reg <= '0; obest_reg <= '0;
            p_nil_reg  <= 1'b0; bad_sym_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        full_reg    <= 1'b0;
                        idx_reg     <= '0;
                        sym_reg     <= SY_W'(in_ch.data.symbol);
                        bad_sym_reg <= 32'(in_ch.data.symbol) >= SYMBOLS;
                        unique case (cmd_t'(in_ch.data.command))
                            CMD_CLEAR:
                            begin
                                count_reg <= '0; last_reg <= '0;
                                cstate_reg <= '0; clen_reg <= '0; best_reg <= '0;
                                cur_reg <= '0;
                                state_reg <= S_NEWROW;   // clear root row
                            end
                            CMD_APPEND:
                            begin
                                state_reg <= S_RD_LEN;
                            end
                            CMD_QSTART:
                            begin
                                cstate_reg <= '0; clen_reg <= '0; best_reg <= '0;
                                state_reg <= S_OUT;
                            end
                            default:
                            begin
                                p_reg <= cstate_reg;
                                curlen_reg <= SL_W'(clen_reg);
                                p_nil_reg <= 1'b0;
                                state_reg <= (32'(in_ch.data.symbol) >= SYMBOLS)
                                             ? S_OUT : S_M_RD;
                                if (32'(in_ch.data.symbol) >= SYMBOLS)
                                begin
                                    cstate_reg <= '0; clen_reg <= '0;
                                end
                            end
                        endcase
                    end
                end
                S_NEWROW:
                begin
                    // one transition of the row cleared per cycle
                    if (idx_reg[SY_W-1:0] == SY_W'(SYMBOLS - 1) || SYMBOLS == 1)
                    begin
                        idx_reg <= '0;
                        state_reg <= (cur_reg == '0) ? S_ROOT : S_WR_CUR;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + SC_W'(1);
                    end
                end
                S_ROOT:
                begin
                    if (init_reg)
                    begin
                        init_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_RD_LEN: state_reg <= S_WT_LEN;
                S_WT_LEN:
                begin
                    lenlast_reg <= ln_rd;
                    if (32'(ln_rd) >= TEXT_LEN)
                    begin
                        full_reg <= 1'b1; state_reg <= S_OUT;
                    end
                    else if (bad_sym_reg)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        cur_reg <= count_reg + ST_W'(1);
                        count_reg <= count_reg + ST_W'(1);
                        p_reg <= last_reg; p_nil_reg <= 1'b0;
                        idx_reg <= '0;
                        state_reg <= S_NEWROW;
                    end
                end
                S_WR_CUR: state_reg <= S_W1_RD;
                S_W1_RD: state_reg <= S_W1_WT;
                S_W1_WT:
                begin
                    if (tr_rd[ST_W])
                    begin
                        q_reg <= tr_rd[ST_W-1:0]; state_reg <= S_Q_LEN;
                    end
                    else
                    begin
                        state_reg <= S_W1_LK;
                    end
                end
                S_W1_LK: state_reg <= S_W1_LKW;
                S_W1_LKW:
                begin
                    if (lk_rd[ST_W])
                    begin
                        p_nil_reg <= 1'b1; state_reg <= S_OUT;
                    end
                    else
                    begin
                        p_reg <= lk_rd[ST_W-1:0]; state_reg <= S_W1_RD;
                    end
                end
                S_Q_LEN: state_reg <= S_Q_LENW;
                S_Q_LENW:
                begin
                    curlen_reg <= ln_rd; state_reg <= S_QP_LEN;
                end
                S_QP_LEN: state_reg <= S_QP_LENW;
                S_QP_LENW:
                begin
                    lenp_reg <= ln_rd;
                    if (ln_rd + SL_W'(1) == curlen_reg)
                    begin
                        idx_reg <= SC_W'(1);   // link cur to q at output
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        cl_reg <= count_reg + ST_W'(1);
                        count_reg <= count_reg + ST_W'(1);
                        idx_reg <= '0;
                        state_reg <= S_CL_RD;
                    end
                end
                S_CL_RD: state_reg <= S_CL_WT;
                S_CL_WT: state_reg <= S_CL_WR;
                S_CL_WR:
                begin
                    idx_reg <= idx_reg + SC_W'(1);
                    state_reg <= (idx_reg[SY_W-1:0] == SY_W'(SYMBOLS - 1))
                                 ? S_CL_LK : S_CL_RD;
                end
                S_CL_LK: state_reg <= S_CL_LKW;
                S_CL_LKW:
                begin
                    qlink_reg <= lk_rd; state_reg <= S_CL_LNK;
                end
                S_CL_LNK:
                begin
                    q_reg <= cl_reg;       // cur links to the clone
                    cl_reg <= q_reg;       // old target for redirect
                    idx_reg <= '0;
                    state_reg <= S_W2_RD;
                end
                S_W2_RD: state_reg <= S_W2_WT;
                S_W2_WT:
                begin
                    if (tr_rd == {1'b1, cl_reg})
                    begin
                        state_reg <= S_W2_LK;
                    end
                    else
                    begin
                        idx_reg <= SC_W'(1); state_reg <= S_OUT;
                    end
                end
                S_W2_LK: state_reg <= S_W2_LKW;
                S_W2_LKW:
                begin
                    if (lk_rd[ST_W])
                    begin
                        idx_reg <= SC_W'(1); state_reg <= S_OUT;
                    end
                    else
                    begin
                        p_reg <= lk_rd[ST_W-1:0]; state_reg <= S_W2_RD;
                    end
                end
                S_M_RD: state_reg <= S_M_WT;
                S_M_WT:
                begin
                    if (tr_rd[ST_W] && count_reg != '0)
                    begin
                        cstate_reg <= tr_rd[ST_W-1:0];
                        clen_reg <= LEN_W'(curlen_reg) + LEN_W'(1);
                        if (LEN_W'(curlen_reg) + LEN_W'(1) > best_reg)
                        begin
                            best_reg <= LEN_W'(curlen_reg) + LEN_W'(1);
                        end
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_M_LK;
                    end
                end
                S_M_LK: state_reg <= S_M_LKW;
                S_M_LKW:
                begin
                    if (lk_rd[ST_W] || p_reg == '0)
                    begin
                        cstate_reg <= '0; clen_reg <= '0; state_reg <= S_OUT;
                    end
                    else
                    begin
                        p_reg <= lk_rd[ST_W-1:0]; state_reg <= S_M_LEN;
                    end
                end
                S_M_LEN: state_reg <= S_M_LENW;
                S_M_LENW:
                begin
                    curlen_reg <= ln_rd; state_reg <= S_M_RD;
                end
                default: // S_OUT
                begin
                    if (!ovalid_reg)
                    begin
                        // a finished append makes the new state the text end
                        if (idx_reg[0] || p_nil_reg)
                        begin
                            last_reg <= cur_reg;
                        end
                        ovalid_reg <= 1'b1;
                        omatch_reg <= clen_reg;
                        obest_reg  <= best_reg;
                        idx_reg    <= '0;
                        p_nil_reg  <= 1'b0;
                        cur_reg    <= '0;
                        state_reg  <= S_IDLE;
                    end
                end
            endcase
        end
    end

    `SA_ASSERT_IMP(a_ready_idle, in_ch.ready, state_reg == S_IDLE,
        "ready outside idle")
    `SA_ASSERT_NEXT(a_accept_busy, in_ch.valid && in_ch.ready, !in_ch.ready,
        "second word accepted while busy")
    `SA_ASSERT_IMP(a_best_ge, state_reg == S_IDLE, best_reg >= clen_reg,
        "best below current length")
endmodule
`default_nettype wire

>>> design/sacs_ram.sv
// single port synchronous ram with registered read data
`default_nettype none
module sacs_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire
